/* hdl/cwo_pkg.sv */
// Package for the caster wheel odometry block: transaction types, command and
// register codes, sequencer states, CORDIC arctangent table and helpers.
// No dependencies.
package cwo_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_STEER   = 2'd0,
    CMD_ROT     = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_RESTART = 2'd3
  } cwo_cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_COUNTS_PER_TURN = 2'd0;
  localparam logic [1:0] REG_GEAR_RATIO      = 2'd1;
  localparam logic [1:0] REG_WHEEL_RADIUS    = 2'd2;
  localparam logic [1:0] REG_AXLE_DISTANCE   = 2'd3;

  localparam int CFG_W = 24;

  // Register reset values
  localparam logic [15:0] RST_COUNTS_PER_TURN = 16'd4096;
  localparam logic [23:0] RST_GEAR_RATIO      = 24'd65536;
  localparam logic [15:0] RST_WHEEL_RADIUS    = 16'd6554;
  localparam logic [19:0] RST_AXLE_DISTANCE   = 20'd65536;

  // 2*pi in Q16 and 65536/pi (twice the binary-angle units per radian)
  localparam logic [18:0] CIRC_SCALE = 19'd411775;
  localparam logic [14:0] YAW_SCALE  = 15'd20861;

  // CORDIC start vector: 1/K in Q30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam int ATAN_DEPTH = 24;
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] count;
  } cwo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } cwo_out_t;

  // sin and cos in Q15, clamped to +-32768
  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
  } cwo_sincos_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_STEER_DIV, S_STEER_FIN, S_ROT, S_RESTART,
    S_GR, S_GR_RND, S_CIRC, S_CIRC_RND, S_TRAV, S_TRAV_SET, S_TRAV_DIV,
    S_TRAV_SAT, S_WAIT_STEER, S_FWD, S_FWD_RND, S_LAT, S_LAT_RND, S_D2,
    S_D2_SET, S_D2_DIV, S_D2_FIN, S_MID, S_WAIT_MID, S_X, S_X_RND, S_X_ACC,
    S_Y, S_Y_RND, S_Y_ACC, S_OUT
  } cwo_state_t;

  // Q30 to Q15, round half up then clamp
  function automatic logic signed [16:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32768) r = 34'sd32768;
    if (r < -34'sd32768) r = -34'sd32768;
    return r[16:0];
  endfunction

  // magnitude of a clamped Q15 value
  function automatic logic [15:0] abs_q15(input logic signed [16:0] v);
    logic signed [16:0] m;
    m = v[16] ? -v : v;
    return m[15:0];
  endfunction

endpackage

/* hdl/cwo_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then a final
// rounding step. Depends on cwo_pkg (arctangent table, Q15 helpers).
module cwo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         angle,
  output logic                busy,
  output cwo_pkg::cwo_sincos_t result
);
  import cwo_pkg::*;

  localparam int SW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [33:0] dx, dy, at;
  logic               flip_r, busy_r, fin_r;
  logic [SW-1:0]      step_r;
  logic [31:0]        z32;
  cwo_sincos_t        res_r;

  // start angle: fold quadrants two and three onto four and one
  always_comb begin
    z32 = {angle, 16'h0000};
    if (angle[15] ^ angle[14]) z32[31] = ~z32[31];
  end

  // one micro-rotation
  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = {2'b00, ATAN_TAB[5'(step_r)]};
    if (!z_r[33]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      step_r <= '0;
      flip_r <= angle[15] ^ angle[14];
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= {{2{z32[31]}}, z32};
    end else if (busy_r && !fin_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (step_r == SW'(CORDIC_STEPS - 1)) fin_r <= 1'b1;
      else step_r <= step_r + 1'b1;
    end else if (fin_r) begin
      res_r.c <= to_q15(flip_r ? -x_r : x_r);
      res_r.s <= to_q15(flip_r ? -y_r : y_r);
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign result = res_r;

endmodule

/* hdl/caster_wheel_odometry_unit.sv */
// Caster wheel odometry top level: sequencer, shared multiplier, bit-serial
// divider and configuration registers. Depends on cwo_pkg and cwo_cordic.
//
// One transaction is taken at a time; in_stall stays high until the work for
// it is done. A steer sample runs the 64-step bit-serial divider. A primed
// tick makes two passes through the divider (travel and yaw change), a CORDIC
// pass for the steer angle and one for the mid-heading, and eight products on
// the shared multiplier, six of them followed by a rounding state. An unprimed
// tick gives no result. The result register lets the next transaction in
// while a pose waits on out_stall.
module caster_wheel_odometry_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_BITS     = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  cwo_pkg::cwo_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output cwo_pkg::cwo_out_t        out_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [cwo_pkg::CFG_W-1:0] cfg_wdata
);
  import cwo_pkg::*;

  localparam int MA   = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int MB   = 27;
  localparam int PW   = MA + MB;
  localparam int DIVW = 64;
  localparam int DCW  = $clog2(DIVW);
  localparam logic [DIVW-1:0] LIM_NEG = DIVW'(1) << (POS_BITS - 1);
  localparam logic [DIVW-1:0] LIM_POS = LIM_NEG - DIVW'(1);

  cwo_state_t state_r, state_nxt;

  // configuration
  logic [15:0] cpt_r, rad_r;
  logic [23:0] gear_r;
  logic [19:0] axle_r;
  logic [15:0] turn;
  logic [19:0] axle_e;

  // odometry state
  logic [15:0] steer_r, last_r, yaw_r;
  logic        primed_r;
  logic [31:0] total_r, tlast_r, x_r, y_r;

  // working registers
  cwo_cmd_t           cmd_r;
  logic signed [15:0] cnt_r;
  logic [PW-1:0]      prod_r;
  logic [MA-1:0]      tmp_r, trav_mag_r, fwd_mag_r;
  logic               dneg_r, trav_neg_r, fwd_neg_r, lat_neg_r;
  logic [31:0]        dmag_r;
  logic [15:0]        dyaw_r, mid_r;
  logic [DIVW-1:0]    num_r;
  logic [19:0]        den_r, rem_r;
  logic [DCW-1:0]     div_cnt_r;
  logic               out_valid_r;
  cwo_out_t           out_data_r;

  // shared units
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic          mul_en;
  logic          cor_start, cor_busy;
  logic [15:0]   cor_angle;
  cwo_sincos_t   cor_res;

  logic          in_acc, out_load;
  logic          div_last;

  assign turn     = (cpt_r == 16'd0) ? 16'd1 : cpt_r;
  assign axle_e   = (axle_r == 20'd0) ? 20'd1 : axle_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign div_last = (div_cnt_r == DCW'(DIVW - 1));

  cwo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cor_start),
    .angle  (cor_angle),
    .busy   (cor_busy),
    .result (cor_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (in_acc) state_nxt = S_DISP;
      S_DISP: begin
        unique case (cmd_r)
          CMD_STEER:   state_nxt = S_STEER_DIV;
          CMD_ROT:     state_nxt = S_ROT;
          CMD_TICK:    state_nxt = primed_r ? S_GR : S_IDLE;
          CMD_RESTART: state_nxt = S_RESTART;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_STEER_DIV:  if (div_last) state_nxt = S_STEER_FIN;
      S_STEER_FIN:  state_nxt = S_IDLE;
      S_ROT:        state_nxt = S_IDLE;
      S_RESTART:    state_nxt = S_IDLE;
      S_GR:         state_nxt = S_GR_RND;
      S_GR_RND:     state_nxt = S_CIRC;
      S_CIRC:       state_nxt = S_CIRC_RND;
      S_CIRC_RND:   state_nxt = S_TRAV;
      S_TRAV:       state_nxt = S_TRAV_SET;
      S_TRAV_SET:   state_nxt = S_TRAV_DIV;
      S_TRAV_DIV:   if (div_last) state_nxt = S_TRAV_SAT;
      S_TRAV_SAT:   state_nxt = S_WAIT_STEER;
      S_WAIT_STEER: if (!cor_busy) state_nxt = S_FWD;
      S_FWD:        state_nxt = S_FWD_RND;
      S_FWD_RND:    state_nxt = S_LAT;
      S_LAT:        state_nxt = S_LAT_RND;
      S_LAT_RND:    state_nxt = S_D2;
      S_D2:         state_nxt = S_D2_SET;
      S_D2_SET:     state_nxt = S_D2_DIV;
      S_D2_DIV:     if (div_last) state_nxt = S_D2_FIN;
      S_D2_FIN:     state_nxt = S_MID;
      S_MID:        state_nxt = S_WAIT_MID;
      S_WAIT_MID:   if (!cor_busy) state_nxt = S_X;
      S_X:          state_nxt = S_X_RND;
      S_X_RND:      state_nxt = S_X_ACC;
      S_X_ACC:      state_nxt = S_Y;
      S_Y:          state_nxt = S_Y_RND;
      S_Y_RND:      state_nxt = S_Y_ACC;
      S_Y_ACC:      state_nxt = S_OUT;
      S_OUT:        if (out_load) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, CORDIC start
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    mul_en    = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_angle = steer_r;
    unique case (state_r)
      S_GR: begin
        mul_a     = MA'(gear_r);
        mul_b     = MB'(rad_r);
        cor_start = 1'b1;
      end
      S_CIRC: begin
        mul_a = tmp_r;
        mul_b = MB'(CIRC_SCALE);
      end
      S_TRAV: begin
        mul_a = MA'(dmag_r);
        mul_b = MB'(tmp_r);
      end
      S_FWD: begin
        mul_a = trav_mag_r;
        mul_b = MB'(abs_q15(cor_res.c));
      end
      S_LAT: begin
        mul_a = trav_mag_r;
        mul_b = MB'(abs_q15(cor_res.s));
      end
      S_D2: begin
        mul_a = tmp_r;
        mul_b = MB'(YAW_SCALE);
      end
      S_MID: begin
        cor_start = 1'b1;
        cor_angle = mid_r;
        mul_en    = 1'b0;
      end
      S_X: begin
        mul_a = fwd_mag_r;
        mul_b = MB'(abs_q15(cor_res.c));
      end
      S_Y: begin
        mul_a = fwd_mag_r;
        mul_b = MB'(abs_q15(cor_res.s));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // rounding of the product: Q16 and Q15 shifts, half up on magnitudes
  logic [PW:0]    rnd16_w, rnd15_w;
  logic [MA-1:0]  rnd16, rnd15;
  assign rnd16_w = {1'b0, prod_r} + (PW + 1)'(32768);
  assign rnd15_w = {1'b0, prod_r} + (PW + 1)'(16384);
  assign rnd16   = MA'(rnd16_w >> 16);
  assign rnd15   = MA'(rnd15_w >> 15);

  // divider step: restoring, one quotient bit a cycle
  logic [20:0] div_trial;
  logic        div_ge;
  logic [20:0] div_diff;
  assign div_trial = {rem_r, num_r[DIVW-1]};
  assign div_ge    = (div_trial >= {1'b0, den_r});
  assign div_diff  = div_trial - {1'b0, den_r};

  // rotation unwrap
  logic [15:0]        last_eff;
  logic signed [17:0] gap_s, half_s;
  logic [31:0]        total_nxt;
  always_comb begin
    last_eff  = primed_r ? last_r : cnt_r;
    gap_s     = 18'(cnt_r) - 18'($signed(last_eff));
    half_s    = {3'b000, cpt_r[15:1]};
    total_nxt = total_r + 32'(gap_s);
    if (gap_s > half_s) total_nxt = total_nxt - {16'h0000, cpt_r};
    else if (gap_s < -half_s) total_nxt = total_nxt + {16'h0000, cpt_r};
  end

  // steer dividend magnitude
  logic [16:0] cnt_mag;
  assign cnt_mag = cnt_r[15] ? 17'(-18'(cnt_r)) : {1'b0, cnt_r};

  // yaw change and half change from the rounded d2 magnitude
  logic [17:0] yaw1_w;
  logic [18:0] yaw2_w;
  logic [15:0] dyaw_m, dhalf_m, dyaw_s, dhalf_s;
  always_comb begin
    yaw1_w  = {1'b0, num_r[16:0]} + 18'd1;
    yaw2_w  = {1'b0, num_r[17:0]} + 19'd2;
    dyaw_m  = yaw1_w[16:1];
    dhalf_m = yaw2_w[17:2];
    dyaw_s  = lat_neg_r ? -dyaw_m : dyaw_m;
    dhalf_s = lat_neg_r ? -dhalf_m : dhalf_m;
  end

  // signed step along x or y
  logic [31:0] step_val;
  logic        step_neg;
  assign step_neg = fwd_neg_r ^ ((state_r == S_X_ACC) ? cor_res.c[16] : cor_res.s[16]);
  assign step_val = step_neg ? -tmp_r[31:0] : tmp_r[31:0];

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpt_r  <= RST_COUNTS_PER_TURN;
      gear_r <= RST_GEAR_RATIO;
      rad_r  <= RST_WHEEL_RADIUS;
      axle_r <= RST_AXLE_DISTANCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNTS_PER_TURN: cpt_r  <= cfg_wdata[15:0];
        REG_GEAR_RATIO:      gear_r <= cfg_wdata[23:0];
        REG_WHEEL_RADIUS:    rad_r  <= cfg_wdata[15:0];
        REG_AXLE_DISTANCE:   axle_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // divider counter
  always_ff @(posedge clk) begin
    if (!rst_n) div_cnt_r <= '0;
    else if (state_r == S_STEER_DIV || state_r == S_TRAV_DIV || state_r == S_D2_DIV)
      div_cnt_r <= div_cnt_r + 1'b1;
  end

  // odometry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r  <= '0;
      last_r   <= '0;
      yaw_r    <= '0;
      primed_r <= 1'b0;
      total_r  <= '0;
      tlast_r  <= '0;
      x_r      <= '0;
      y_r      <= '0;
    end else begin
      case (state_r)
        S_STEER_FIN: steer_r <= cnt_r[15] ? -num_r[15:0] : num_r[15:0];
        S_ROT: begin
          primed_r <= 1'b1;
          last_r   <= cnt_r;
          total_r  <= total_nxt;
        end
        S_RESTART: begin
          primed_r <= 1'b0;
          total_r  <= '0;
          tlast_r  <= '0;
          x_r      <= '0;
          y_r      <= '0;
          yaw_r    <= '0;
        end
        S_GR:    tlast_r <= total_r;
        S_X_ACC: x_r <= x_r + step_val;
        S_Y_ACC: begin
          y_r   <= y_r + step_val;
          yaw_r <= yaw_r + dyaw_r;
        end
        default: ;
      endcase
    end
  end

  // datapath working registers
  logic [31:0] du;
  assign du = total_r - tlast_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cwo_cmd_t'(in_data.command);
      cnt_r <= in_data.count;
    end
    if (mul_en) prod_r <= PW'(mul_a * mul_b);
    case (state_r)
      S_DISP: begin
        num_r <= DIVW'({cnt_mag, 16'h0000}) + DIVW'(turn >> 1);
        den_r <= 20'(turn);
        rem_r <= '0;
      end
      S_STEER_DIV, S_TRAV_DIV, S_D2_DIV: begin
        num_r <= {num_r[DIVW-2:0], div_ge};
        rem_r <= div_ge ? div_diff[19:0] : div_trial[19:0];
      end
      S_GR: begin
        dneg_r <= du[31];
        dmag_r <= du[31] ? -du : du;
      end
      S_GR_RND, S_CIRC_RND: tmp_r <= rnd16;
      S_TRAV_SET: begin
        num_r <= DIVW'(prod_r) + DIVW'(turn >> 1);
        den_r <= 20'(turn);
        rem_r <= '0;
      end
      S_TRAV_SAT: begin
        trav_neg_r <= !dneg_r;
        if (!dneg_r) trav_mag_r <= MA'((num_r > LIM_NEG) ? LIM_NEG : num_r);
        else trav_mag_r <= MA'((num_r > LIM_POS) ? LIM_POS : num_r);
      end
      S_FWD_RND: begin
        fwd_mag_r <= rnd15;
        fwd_neg_r <= trav_neg_r ^ cor_res.c[16];
      end
      S_LAT_RND: begin
        tmp_r     <= rnd15;
        lat_neg_r <= trav_neg_r ^ cor_res.s[16];
      end
      S_D2_SET: begin
        num_r <= DIVW'(prod_r) + DIVW'(axle_e >> 1);
        den_r <= axle_e;
        rem_r <= '0;
      end
      S_D2_FIN: begin
        dyaw_r <= dyaw_s;
        mid_r  <= yaw_r + dhalf_s;
      end
      S_X_RND, S_Y_RND: tmp_r <= rnd15;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pos_x   <= x_r;
      out_data_r.pos_y   <= y_r;
      out_data_r.heading <= yaw_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // the forward split must see a finished steer CORDIC
  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD) |-> !cor_busy)
    else $error("steer CORDIC still busy at forward split");

  // every division starts from a cleared bit counter
  a_div_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (div_cnt_r == '0))
    else $error("divider counter not cleared when idle");

  // a pose load always shows up as a pending result
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && out_data_r.heading == $past(yaw_r)))
    else $error("pose not loaded into result register");

  // a tick never changes the priming of the rotation unwrap
  a_tick_primed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && cmd_r == CMD_TICK) |=> $stable(primed_r))
    else $error("tick altered rotation priming");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for caster_wheel_odometry_unit: a local pose predictor
// checks every result transaction under random idling and back-pressure.
// Depends on cwo_pkg and the RTL of the odometry unit.
`timescale 1ns / 100ps

module testbench;
  import cwo_pkg::*;

  localparam int CORDIC_N  = 16;
  localparam int IDLE_PCT  = 38;
  localparam int DRAIN_CYC = 300;
  localparam int WDOG_MAX  = 20000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cwo_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  cwo_out_t             out_data;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  caster_wheel_odometry_unit #(.CORDIC_STEPS(CORDIC_N), .POS_BITS(32)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Arctangent steps in Q32 turns for the pose predictor
  localparam logic [31:0] ANGLE_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D
  };

  // Predictor copy of the registers and odometry state
  logic [15:0] m_turn;
  logic [23:0] m_gear;
  logic [15:0] m_radius;
  logic [19:0] m_axle;
  logic [15:0] m_steer, m_last, m_yaw;
  logic        m_primed;
  logic [31:0] m_total, m_total_tick, m_x, m_y;

  cwo_out_t pose_queue[$];
  int       fail_count;
  bit       calm;          // no idling on either side
  int       hold_gen, hold_done, hold_left;
  logic signed [15:0] rot_pos; // last rotation count sent, for smooth sequences

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round to nearest, ties away from zero
  function automatic longint div_round(longint n, longint d);
    longint m;
    m = (n < 0) ? -n : n;
    m = (m + d / 2) / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint q30_to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // CORDIC rotation of a binary angle into Q15 sine and cosine
  task automatic angle_sincos(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] z32;
    bit          flip;
    longint      x, y, z, dx, dy;
    z32  = {ang, 16'h0000};
    flip = (z32[31:30] == 2'd1) || (z32[31:30] == 2'd2);
    if (flip) z32 = z32 + 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'(signed'(z32));
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ANGLE_STEP[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ANGLE_STEP[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = q30_to_q15(y);
    c = q30_to_q15(x);
  endtask

  // Advance the odometry state by one input transaction
  task automatic predict_pose(input cwo_cmd_t cmd, input logic signed [15:0] cnt,
                              output bit has_pose, output cwo_out_t pose);
    longint turn, axle, half, gap, dcount, gr, circ, travel;
    longint ss, cs, sm, cm, fwd, lat, d2, dyaw, dhalf;
    logic [31:0] t;
    logic [15:0] mid;
    has_pose = 1'b0;
    pose     = '0;
    turn = (m_turn != 0) ? longint'(m_turn) : 1;
    axle = (m_axle != 0) ? longint'(m_axle) : 1;
    case (cmd)
      CMD_STEER: begin
        m_steer = 16'(div_round(longint'(cnt) * 65536, turn));
      end
      CMD_ROT: begin
        half = longint'(m_turn / 2);
        if (!m_primed) begin
          m_last   = cnt;
          m_primed = 1'b1;
        end
        gap    = longint'(cnt) - longint'(signed'(m_last));
        m_last = cnt;
        t = m_total + 32'(gap);
        if (gap > half) t = t - 32'(m_turn);
        else if (gap < -half) t = t + 32'(m_turn);
        m_total = t;
      end
      CMD_RESTART: begin
        m_primed = 1'b0;
        m_total = '0; m_total_tick = '0;
        m_x = '0; m_y = '0; m_yaw = '0;
      end
      default: begin
        if (m_primed) begin
          dcount = longint'(signed'(m_total - m_total_tick));
          gr     = (longint'(m_gear) * longint'(m_radius) + 32768) >>> 16;
          circ   = (gr * 411775 + 32768) >>> 16;
          travel = div_round(-dcount * circ, turn);
          if (travel > 64'sd2147483647) travel = 64'sd2147483647;
          if (travel < -64'sd2147483648) travel = -64'sd2147483648;
          m_total_tick = m_total;
          angle_sincos(m_steer, ss, cs);
          fwd   = div_round(travel * cs, 32768);
          lat   = div_round(travel * ss, 32768);
          d2    = div_round(lat * 20861, axle);
          dyaw  = div_round(d2, 2);
          dhalf = div_round(d2, 4);
          mid   = m_yaw + 16'(dhalf);
          angle_sincos(mid, sm, cm);
          m_x   = m_x + 32'(div_round(fwd * cm, 32768));
          m_y   = m_y + 32'(div_round(fwd * sm, 32768));
          m_yaw = m_yaw + 16'(dyaw);
          has_pose      = 1'b1;
          pose.pos_x    = m_x;
          pose.pos_y    = m_y;
          pose.heading  = m_yaw;
        end
      end
    endcase
  endtask

  // Offer one transaction, wait for acceptance, then maybe idle
  task automatic send_item(input cwo_cmd_t cmd, input logic signed [15:0] cnt);
    bit       has_pose;
    cwo_out_t pose;
    in_valid        <= 1'b1;
    in_data.command <= cmd;
    in_data.count   <= cnt;
    do @(posedge clk); while (in_stall);
    predict_pose(cmd, cnt, has_pose, pose);
    if (has_pose) pose_queue.push_back(pose);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Let the block drain and settle before touching registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_we after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_COUNTS_PER_TURN: m_turn   = val[15:0];
      REG_GEAR_RATIO:      m_gear   = val[23:0];
      REG_WHEEL_RADIUS:    m_radius = val[15:0];
      default:             m_axle   = val[19:0];
    endcase
  endtask

  task automatic set_geometry(input logic [15:0] turn, input logic [23:0] gear,
                              input logic [15:0] radius, input logic [19:0] axle);
    wait_quiet();
    write_reg(REG_COUNTS_PER_TURN, CFG_W'(turn));
    write_reg(REG_GEAR_RATIO, gear);
    write_reg(REG_WHEEL_RADIUS, CFG_W'(radius));
    write_reg(REG_AXLE_DISTANCE, CFG_W'(axle));
    cfg_we <= 1'b0;
  endtask

  // One random transaction, mostly well-formed motion with some noise
  task automatic send_random();
    int pick;
    logic signed [15:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      v = (pick < 3) ? 16'($urandom) : 16'(signed'($urandom_range(0, 4000)) - 2000);
      send_item(CMD_STEER, v);
    end else if (pick < 60) begin
      if (pick < 48) rot_pos = rot_pos + 16'(signed'($urandom_range(0, 800)) - 400);
      else rot_pos = 16'($urandom);
      send_item(CMD_ROT, rot_pos);
    end else if (pick < 96) begin
      send_item(CMD_TICK, 16'($urandom));
    end else begin
      send_item(CMD_RESTART, 16'($urandom));
    end
  endtask

  // Extremes of every field, every command and the unprimed and wrap cases
  task automatic test_directed();
    send_item(CMD_TICK, 16'sd0);              // unprimed tick: no pose
    send_item(CMD_STEER, 16'sh7FFF);
    send_item(CMD_STEER, -16'sd32768);
    send_item(CMD_STEER, 16'sd1024);          // quarter turn
    send_item(CMD_ROT, 16'sd100);             // primes only
    send_item(CMD_TICK, 16'sd0);
    send_item(CMD_ROT, 16'sd300);
    send_item(CMD_TICK, -16'sd1);
    send_item(CMD_STEER, 16'sd0);
    send_item(CMD_ROT, 16'sd4000);            // forward jump past half turn
    send_item(CMD_ROT, 16'sd10);              // backward wrap
    send_item(CMD_TICK, 16'sd0);
    send_item(CMD_ROT, 16'sh7FFF);
    send_item(CMD_ROT, -16'sd32768);
    send_item(CMD_TICK, 16'sh5555);
    send_item(CMD_STEER, -16'sd2048);         // half turn
    send_item(CMD_ROT, -16'sd32000);
    send_item(CMD_TICK, 16'shAAAA);
    send_item(CMD_RESTART, 16'sd0);
    send_item(CMD_TICK, 16'sd0);              // unprimed after restart
    send_item(CMD_ROT, 16'sd5);
    send_item(CMD_ROT, 16'sd900);
    send_item(CMD_TICK, 16'sd0);
    send_item(CMD_TICK, 16'sd0);              // no motion since last tick
    rot_pos = 16'sd900;
  endtask

  // Several geometries, the extremes and the divide-by-zero cases among them
  task automatic test_geometry();
    logic [15:0] turns [6]  = '{16'd2, 16'd65535, 16'd0, 16'd360, 16'd4096, 16'd1000};
    logic [23:0] gears [6]  = '{24'hFFFFFF, 24'd0, 24'd65536, 24'd131072, 24'd1, 24'd70000};
    logic [15:0] radii [6]  = '{16'hFFFF, 16'd1, 16'd6554, 16'd20000, 16'd6554, 16'd3000};
    logic [19:0] axles [6]  = '{20'd1, 20'hFFFFF, 20'd0, 20'd32768, 20'd65536, 20'd90000};
    for (int k = 0; k < 6; k++) begin
      set_geometry(turns[k], gears[k], radii[k], axles[k]);
      send_item(CMD_RESTART, 16'sd0);
      for (int n = 0; n < 50; n++) send_random();
    end
  endtask

  // Bulk random traffic, with a stretch free of idling in the middle
  task automatic test_random();
    set_geometry(16'd4096, 24'd65536, 16'd6554, 20'd65536);
    for (int n = 0; n < 680; n++) begin
      calm = (n >= 250 && n < 400);
      send_random();
    end
    calm = 1'b0;
  endtask

  // Receiver holds off for a long time while ticks keep arriving
  task automatic test_backpressure();
    wait_quiet();
    hold_gen = hold_gen + 1;
    for (int n = 0; n < 40; n++) begin
      rot_pos = rot_pos + 16'sd37;
      send_item((n % 2 == 0) ? CMD_ROT : CMD_TICK, rot_pos);
    end
  endtask

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_gen != hold_done) begin
      hold_done <= hold_gen;
      hold_left <= 1500;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Result checker and watchdog
  int quiet_cycles;
  always @(posedge clk) begin
    cwo_out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("[caster_wheel_odometry_unit] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pose_queue.size() == 0) begin
          $display("%0t: unexpected pose x=%0d y=%0d heading=%0d", $time,
                   out_data.pos_x, out_data.pos_y, out_data.heading);
          fail_count++;
        end else begin
          want = pose_queue.pop_front();
          if (out_data.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, out_data.pos_x);
            fail_count++;
          end
          if (out_data.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, out_data.pos_y);
            fail_count++;
          end
          if (out_data.heading !== want.heading) begin
            $display("%0t: heading expected %0d got %0d", $time, want.heading,
                     out_data.heading);
            fail_count++;
          end
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Test sequence
  initial begin
    fail_count = 0;
    calm       = 1'b0;
    hold_gen   = 0;
    rot_pos    = '0;
    m_turn = RST_COUNTS_PER_TURN; m_gear = RST_GEAR_RATIO;
    m_radius = RST_WHEEL_RADIUS; m_axle = RST_AXLE_DISTANCE;
    m_steer = '0; m_last = '0; m_yaw = '0; m_primed = 1'b0;
    m_total = '0; m_total_tick = '0; m_x = '0; m_y = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_geometry();
    test_random();
    test_backpressure();

    wait_quiet();
    if (fail_count == 0) $display("[caster_wheel_odometry_unit] OK");
    else $display("[caster_wheel_odometry_unit] ERROR");
    $finish;
  end

endmodule
